// File: rtl/core/dhf_pkg.sv
// Shared types and constants of the depth hole-fill and spike filter.
// No dependencies; imported by every module of the block except dhf_ram.
package dhf_pkg;

  localparam int PIXEL_BITS  = 8;
  localparam int EDGE_MARGIN = 2;
  localparam int COORD_BITS  = 11;
  localparam int REG_BITS    = 12;
  localparam int MIN_SIDE    = 5;
  localparam int COORD_LIMIT = 2048;

  typedef logic [PIXEL_BITS-1:0] pixel_t;
  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic [REG_BITS-1:0]   size_t;

  // One window column, top row oldest.
  typedef struct packed {
    pixel_t top;
    pixel_t mid;
    pixel_t bot;
  } column_t;

  // Center pixel and its four direct neighbours.
  typedef struct packed {
    pixel_t up;
    pixel_t cur;
    pixel_t down;
    pixel_t left;
    pixel_t right;
  } cross_t;

  // Register indexes.
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_THRESH = 2'd2;

  // Result slots of one input beat, in emission order.
  localparam logic [1:0] RES_DIAG = 2'd0;  // pixel one row up, one column left
  localparam logic [1:0] RES_EDGE = 2'd1;  // last column of the row above
  localparam logic [1:0] RES_LAST = 2'd2;  // the pixel itself, last row only

  localparam int RES_SLOTS = 3;

endpackage

// File: rtl/core/dhf_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module dhf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/core/dhf_cell.sv
// Window cell: holds one 3-pixel column and hands it to the next cell.
// Depends on dhf_pkg.
module dhf_cell (
  input  logic             clk,
  input  logic             rst,
  input  logic             shift,
  input  dhf_pkg::column_t col_in,
  output dhf_pkg::column_t col_out
);
  import dhf_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_out <= '0;
    end else if (shift) begin
      col_out <= col_in;
    end
  end

endmodule

// File: rtl/core/dhf_filter.sv
// Hole fill and spike test on the window center.
// Depends on dhf_pkg.
module dhf_filter (
  input  dhf_pkg::cross_t win,
  input  dhf_pkg::pixel_t thresh,
  output dhf_pkg::pixel_t result
);
  import dhf_pkg::*;

  logic [PIXEL_BITS:0] lim_left, lim_right, lim_up, lim_down;
  logic [PIXEL_BITS:0] cur_x, sum_h, sum_v;
  logic                spike_h, spike_v;

  always_comb begin
    cur_x     = {1'b0, win.cur};
    lim_left  = {1'b0, win.left}  + {1'b0, thresh};
    lim_right = {1'b0, win.right} + {1'b0, thresh};
    lim_up    = {1'b0, win.up}    + {1'b0, thresh};
    lim_down  = {1'b0, win.down}  + {1'b0, thresh};
    sum_h     = {1'b0, win.left} + {1'b0, win.right};
    sum_v     = {1'b0, win.up}   + {1'b0, win.down};
    spike_h   = (win.left != '0) && (win.right != '0) &&
                (cur_x > lim_left) && (cur_x > lim_right);
    spike_v   = (win.up != '0) && (win.down != '0) &&
                (cur_x > lim_up) && (cur_x > lim_down);
    priority if (win.cur == '0) begin
      if (win.up != '0) begin
        result = win.up;
      end else begin
        result = win.left;
      end
    end else if (spike_h) begin
      result = sum_h[PIXEL_BITS:1];
    end else if (spike_v) begin
      result = sum_v[PIXEL_BITS:1];
    end else begin
      result = win.cur;
    end
  end

endmodule

// File: rtl/core/depth_hole_fill_spike_filter.sv
// Top level of the depth hole-fill and spike filter: position tracking,
// line buffer, window cells, filter and result sequencing.
// Depends on dhf_pkg, dhf_ram, dhf_cell, dhf_filter.
//
//  channel | handshake                  | payload
//  --------+----------------------------+-------------------------------------
//  in      | in_valid / in_stall        | depth_in, frame_start
//  out     | out_valid / out_stall      | depth_out, out_row, out_col,
//          |                            | run_last, frame_done
//  cfg     | psel penable pwrite pready | paddr, pwdata, prdata
//
// An input beat passes a line buffer read stage and then a result stage that
// emits its 0 to 3 result beats at one per cycle while out is not stalled; a
// beat has two or three results at the end of a row below the first and on
// the last row from its second column on. The result stage takes the next
// beat as its last result is accepted. Stalls on out hold the result stage
// and back up into in_stall. Synchronous reset clears counters and window and
// loads the registers with their defaults; the line buffer is not cleared.
module depth_hole_fill_spike_filter #(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  dhf_pkg::pixel_t       depth_in,
  input  logic                  frame_start,
  output logic                  out_valid,
  input  logic                  out_stall,
  output dhf_pkg::pixel_t       depth_out,
  output dhf_pkg::coord_t       out_row,
  output dhf_pkg::coord_t       out_col,
  output logic                  run_last,
  output logic                  frame_done,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [3:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);
  import dhf_pkg::*;

  localparam int ADDR_W = $clog2(MAX_WIDTH);
  localparam int W_LIM  = (MAX_WIDTH < COORD_LIMIT) ? MAX_WIDTH : COORD_LIMIT;
  localparam int LINE_W = 2 * PIXEL_BITS;

  // Configuration registers.
  size_t  image_width, image_height;
  pixel_t spike_threshold;
  size_t  eff_w, eff_h;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width     <= size_t'(640);
      image_height    <= size_t'(480);
      spike_threshold <= pixel_t'(5);
    end else if (psel && penable && pwrite && pready) begin
      unique case (paddr[3:2])
        REG_WIDTH:  image_width     <= pwdata[REG_BITS-1:0];
        REG_HEIGHT: image_height    <= pwdata[REG_BITS-1:0];
        REG_THRESH: spike_threshold <= pwdata[PIXEL_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_WIDTH:  prdata = 32'(image_width);
      REG_HEIGHT: prdata = 32'(image_height);
      REG_THRESH: prdata = 32'(spike_threshold);
      default:    prdata = '0;
    endcase
  end

  always_comb begin
    if (image_width < size_t'(MIN_SIDE)) begin
      eff_w = size_t'(MIN_SIDE);
    end else if (image_width > size_t'(W_LIM)) begin
      eff_w = size_t'(W_LIM);
    end else begin
      eff_w = image_width;
    end
    if (image_height < size_t'(MIN_SIDE)) begin
      eff_h = size_t'(MIN_SIDE);
    end else if (image_height > size_t'(COORD_LIMIT)) begin
      eff_h = size_t'(COORD_LIMIT);
    end else begin
      eff_h = image_height;
    end
  end

  // Handshake.
  logic in_accept, out_accept, s1_adv, s2_free, s2_last;
  logic s1_valid, s2_valid;

  // Position of the incoming beat.
  size_t row_count, col_count;
  size_t col_pre, row_pre, row_step, c_now, r_now;
  logic [RES_SLOTS-1:0] mask_now;
  logic inner_now, done_now;
  logic [ADDR_W-1:0] addr_now;

  always_comb begin
    col_pre = frame_start ? '0 : col_count;
    row_pre = frame_start ? '0 : row_count;
    if (col_pre >= eff_w) begin
      c_now    = '0;
      row_step = row_pre + size_t'(1);
    end else begin
      c_now    = col_pre;
      row_step = row_pre;
    end
    r_now     = (row_step >= eff_h) ? '0 : row_step;
    inner_now = (r_now >= size_t'(EDGE_MARGIN + 1)) &&
                ((r_now + size_t'(EDGE_MARGIN - 1)) < eff_h) &&
                (c_now >= size_t'(EDGE_MARGIN + 1)) &&
                ((c_now + size_t'(EDGE_MARGIN - 1)) < eff_w);
    done_now  = (c_now == eff_w - size_t'(1));
    mask_now[RES_DIAG] = (r_now != '0) && (c_now != '0);
    mask_now[RES_EDGE] = (r_now != '0) && done_now;
    mask_now[RES_LAST] = (r_now == eff_h - size_t'(1));
    addr_now = ADDR_W'(c_now);
  end

  // End of row and end of frame wrap with the sizes in force for this beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      row_count <= '0;
      col_count <= '0;
    end else if (in_accept) begin
      if (done_now) begin
        col_count <= '0;
        row_count <= mask_now[RES_LAST] ? '0 : r_now + size_t'(1);
      end else begin
        row_count <= r_now;
        col_count <= c_now + size_t'(1);
      end
    end
  end

  // Line buffer read stage.
  pixel_t               s1_d;
  coord_t               s1_r, s1_c;
  logic [RES_SLOTS-1:0] s1_mask;
  logic                 s1_inner, s1_done;
  logic [ADDR_W-1:0]    s1_addr;
  logic [LINE_W-1:0]    ram_rdata, line_rd, line_wr, fwd_data;
  logic                 fwd_hit;
  pixel_t               older_rd, prior_rd;

  assign in_stall  = s1_valid && !s1_adv;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      fwd_hit  <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_valid <= 1'b1;
        fwd_hit  <= s1_adv && (s1_addr == addr_now);
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_d     <= depth_in;
      s1_r     <= r_now[COORD_BITS-1:0];
      s1_c     <= c_now[COORD_BITS-1:0];
      s1_mask  <= mask_now;
      s1_inner <= inner_now;
      s1_done  <= done_now;
      s1_addr  <= addr_now;
      fwd_data <= line_wr;
    end
  end

  assign line_rd  = fwd_hit ? fwd_data : ram_rdata;
  assign older_rd = line_rd[LINE_W-1:PIXEL_BITS];
  assign prior_rd = line_rd[PIXEL_BITS-1:0];
  assign line_wr  = {prior_rd, s1_d};

  dhf_ram #(
    .WIDTH (LINE_W),
    .DEPTH (MAX_WIDTH)
  ) u_line (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_addr),
    .wdata (line_wr),
    .re    (in_accept),
    .raddr (addr_now),
    .rdata (ram_rdata)
  );

  // Window cells: cell 0 holds the newest column, cell 1 the one before.
  column_t col_new, col0, col1;
  cross_t  win;
  pixel_t  filt;

  assign col_new = '{top: older_rd, mid: prior_rd, bot: s1_d};

  dhf_cell u_cell0 (
    .clk     (clk),
    .rst     (rst),
    .shift   (s1_adv),
    .col_in  (col_new),
    .col_out (col0)
  );

  dhf_cell u_cell1 (
    .clk     (clk),
    .rst     (rst),
    .shift   (s1_adv),
    .col_in  (col0),
    .col_out (col1)
  );

  assign win = '{up: col0.top, cur: col0.mid, down: col0.bot,
                 left: col1.mid, right: prior_rd};

  dhf_filter u_filter (
    .win    (win),
    .thresh (spike_threshold),
    .result (filt)
  );

  // Result stage.
  logic [RES_SLOTS-1:0] s2_mask;
  pixel_t               s2_diag, s2_edge, s2_self;
  coord_t               s2_r, s2_c;
  logic                 s2_done;
  logic [1:0]           sel;

  assign out_accept = s2_valid && !out_stall;
  assign run_last   = ((s2_mask & (s2_mask - RES_SLOTS'(1))) == '0);
  assign s2_last    = out_accept && run_last;
  assign s2_free    = !s2_valid || s2_last;
  assign s1_adv     = s1_valid && s2_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
      s2_mask  <= '0;
    end else begin
      if (s1_adv && (s1_mask != '0)) begin
        s2_valid <= 1'b1;
        s2_mask  <= s1_mask;
      end else if (out_accept) begin
        s2_mask <= s2_mask & (s2_mask - RES_SLOTS'(1));
        if (run_last) begin
          s2_valid <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && (s1_mask != '0)) begin
      s2_diag <= s1_inner ? filt : col0.mid;
      s2_edge <= prior_rd;
      s2_self <= s1_d;
      s2_r    <= s1_r;
      s2_c    <= s1_c;
      s2_done <= s1_done;
    end
  end

  always_comb begin
    priority if (s2_mask[RES_DIAG]) begin
      sel = RES_DIAG;
    end else if (s2_mask[RES_EDGE]) begin
      sel = RES_EDGE;
    end else begin
      sel = RES_LAST;
    end
  end

  assign out_valid = s2_valid;

  always_comb begin
    unique case (sel)
      RES_DIAG: begin
        depth_out  = s2_diag;
        out_row    = s2_r - coord_t'(1);
        out_col    = s2_c - coord_t'(1);
        frame_done = 1'b0;
      end
      RES_EDGE: begin
        depth_out  = s2_edge;
        out_row    = s2_r - coord_t'(1);
        out_col    = s2_c;
        frame_done = 1'b0;
      end
      default: begin
        depth_out  = s2_self;
        out_row    = s2_r;
        out_col    = s2_c;
        frame_done = s2_done;
      end
    endcase
  end

endmodule

// File: rtl/core/dhf_checker.sv
// Port-level checks of the depth hole-fill and spike filter, bound to the top.
// Depends on dhf_pkg and depth_hole_fill_spike_filter.
module dhf_checker (
  input logic            clk,
  input logic            rst,
  input logic            out_valid,
  input logic            out_stall,
  input dhf_pkg::pixel_t depth_out,
  input dhf_pkg::coord_t out_row,
  input dhf_pkg::coord_t out_col,
  input logic            run_last,
  input logic            frame_done
);
  import dhf_pkg::*;

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(depth_out) &&
      $stable(out_row) && $stable(out_col) && $stable(run_last) &&
      $stable(frame_done))
    else $error("stalled result beat changed");

  // The end of frame result is always the last of its input beat.
  a_done_last: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_done |-> run_last)
    else $error("frame_done without run_last");

  // Results of one input beat go out without gaps.
  a_run_cont: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !run_last |=> out_valid)
    else $error("gap inside a result run");

  // Nothing pending right after reset.
  a_reset_idle: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid after reset");

endmodule

bind depth_hole_fill_spike_filter dhf_checker u_dhf_checker (.*);
